// ----- design/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, constants and helpers of the playfair cipher engine
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int LETTER_W = 5;
	localparam int CMD_W    = 3;
	localparam int COORD_W  = 3;
	localparam int POS_W    = 2 * COORD_W;
	localparam int CELLS    = 25;
	localparam int ALPHABET = 26;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
	localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
	localparam logic [LETTER_W-1:0] SLOT_FULL   = 5'd25;
	localparam logic [COORD_W-1:0]  SIDE_LAST   = 3'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 3'd0,
		CMD_KEY   = 3'd1,
		CMD_FILL  = 3'd2,
		CMD_TEXT  = 3'd3,
		CMD_END   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		OP_CLR,
		OP_PLACE,
		OP_FILL,
		OP_PAIR
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [LETTER_W-1:0] a;
		logic [LETTER_W-1:0] b;
	} qent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_RDB,
		ST_CALC,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	// j shares the i cell
	function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] c);
		return (c == LETTER_J) ? LETTER_I : c;
	endfunction

endpackage

// ----- design/playfair_cipher_top.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_top
// playfair digraph cipher over a 5x5 key square, letters coded a=0 to z=25
// ----------------------------------------------------------------------------
// commands arrive on the slave stream (tuser = command, tdata = letter) and
// cipher letters leave on the master stream, two items per digraph with tlast
// on the second. a front stage folds j into i, pairs text letters (a doubled
// letter or a lone letter at end of text is padded with x) and drops letters
// above z and unknown commands; a two-entry queue then hands the work to a
// back stage that owns the key square. a key letter or start key is done from
// idle, complete key walks the whole alphabet, and a digraph runs two reads
// of the letter position ram, a compute-and-read of the square ram and one
// emit state per item, as each ram has a single read port. the front keeps
// taking commands while the queue has room, and the output register lets the
// back stage work on the next digraph while a letter waits. the user must
// write the mode register (0 encrypt, 1 decrypt) through cfg_wen/cfg_wdata
// only while the block is idle; the block does not enforce it. text must
// follow a complete key: before that the square holds stale cells.
module playfair_cipher_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wen,
	input  logic       cfg_wdata,   // mode
	// command stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [4:0] letter, [7:5] zero
	input  logic [2:0] s_tuser,     // [2:0] cmd
	// cipher letter stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [4:0] out_letter, [7:5] zero
	output logic       m_tlast      // second letter of a digraph
);

	logic                         mode_q;
	logic                         accept;
	logic                         q_push;
	pfc_pkg::qent_t               q_push_data;
	logic                         q_full;
	logic                         q_pop;
	pfc_pkg::qent_t               q_pop_data;
	logic                         q_empty;
	logic [pfc_pkg::LETTER_W-1:0] out_letter;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// an item is taken whenever the queue has room
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	pfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (s_tuser),
		.letter   (s_tdata[pfc_pkg::LETTER_W-1:0]),
		.push     (q_push),
		.push_data(q_push_data)
	);

	pfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	pfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.q_empty   (q_empty),
		.q_data    (q_pop_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_letter(out_letter),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_letter};

endmodule

// ----- design/pfc_ram.sv -----
// ----------------------------------------------------------------------------
// pfc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/pfc_queue.sv -----
// ----------------------------------------------------------------------------
// pfc_queue
// short fifo of classified operations between front and back
// ----------------------------------------------------------------------------
module pfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfc_pkg::qent_t push_data,
	output logic          full,
	input  logic          pop,
	output pfc_pkg::qent_t pop_data,
	output logic          empty
);

	pfc_pkg::qent_t                   mem_q [pfc_pkg::QDEPTH];
	logic [pfc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [pfc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [pfc_pkg::QCNT_W-1:0]       count_q;
	logic                             do_push;
	logic                             do_pop;

	localparam logic [pfc_pkg::QPTR_W-1:0] PTR_LAST = pfc_pkg::QPTR_W'(pfc_pkg::QDEPTH - 1);
	localparam logic [pfc_pkg::QCNT_W-1:0] CNT_FULL = pfc_pkg::QCNT_W'(pfc_pkg::QDEPTH);

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/pfc_front.sv -----
// ----------------------------------------------------------------------------
// pfc_front
// takes commands, folds letters, forms digraphs and queues the work
// ----------------------------------------------------------------------------
module pfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [pfc_pkg::CMD_W-1:0]     cmd,
	input  logic [pfc_pkg::LETTER_W-1:0]  letter,
	output logic                          push,
	output pfc_pkg::qent_t                push_data
);

	logic [pfc_pkg::LETTER_W-1:0] pend_q;
	logic                         pend_vld_q;
	logic [pfc_pkg::LETTER_W-1:0] pend_d;
	logic                         pend_vld_d;
	logic [pfc_pkg::LETTER_W-1:0] folded;
	logic                         in_range;

	assign folded   = pfc_pkg::fold(letter);
	assign in_range = (letter <= pfc_pkg::LETTER_LAST);

	always_comb begin
		push           = 1'b0;
		push_data.op   = pfc_pkg::OP_CLR;
		push_data.a    = folded;
		push_data.b    = pfc_pkg::LETTER_X;
		pend_d         = pend_q;
		pend_vld_d     = pend_vld_q;
		case (pfc_pkg::cmd_t'(cmd))
			pfc_pkg::CMD_START: begin
				push       = accept;
				pend_d     = '0;
				pend_vld_d = 1'b0;
			end
			pfc_pkg::CMD_KEY: begin
				push         = accept && in_range;
				push_data.op = pfc_pkg::OP_PLACE;
			end
			pfc_pkg::CMD_FILL: begin
				push         = accept;
				push_data.op = pfc_pkg::OP_FILL;
			end
			pfc_pkg::CMD_TEXT: begin
				push_data.op = pfc_pkg::OP_PAIR;
				push_data.a  = pend_q;
				if (in_range) begin
					if (!pend_vld_q) begin
						pend_d     = folded;
						pend_vld_d = 1'b1;
					end else if (folded == pend_q) begin
						// doubled letter: pad with x, letter stays pending
						push = accept;
					end else begin
						push        = accept;
						push_data.b = folded;
						pend_vld_d  = 1'b0;
					end
				end
			end
			pfc_pkg::CMD_END: begin
				push_data.op = pfc_pkg::OP_PAIR;
				push_data.a  = pend_q;
				push         = accept && pend_vld_q;
				pend_vld_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
		end else if (accept) begin
			pend_q     <= pend_d;
			pend_vld_q <= pend_vld_d;
		end
	end

endmodule

// ----- design/pfc_back.sv -----
// ----------------------------------------------------------------------------
// pfc_back
// builds the key square and ciphers queued digraphs
// ----------------------------------------------------------------------------
module pfc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode,
	input  logic                          q_empty,
	input  pfc_pkg::qent_t                q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pfc_pkg::LETTER_W-1:0]  out_letter,
	output logic                          out_last
);

	pfc_pkg::state_t              state_q;
	pfc_pkg::state_t              state_d;

	logic [pfc_pkg::ALPHABET-1:0] placed_q;
	logic [pfc_pkg::LETTER_W-1:0] slot_q;
	logic [pfc_pkg::COORD_W-1:0]  slot_row_q;
	logic [pfc_pkg::COORD_W-1:0]  slot_col_q;
	logic [pfc_pkg::LETTER_W-1:0] cnt_q;
	logic [pfc_pkg::LETTER_W-1:0] b_q;
	logic [pfc_pkg::POS_W-1:0]    pos_a_q;
	logic [pfc_pkg::LETTER_W-1:0] idx2_q;

	logic                         out_valid_q;
	logic [pfc_pkg::LETTER_W-1:0] out_letter_q;
	logic                         out_last_q;

	logic                         out_free;
	logic                         place_en;
	logic                         place_ok;
	logic                         clr;
	logic [pfc_pkg::LETTER_W-1:0] place_letter;
	logic                         pos_re;
	logic [pfc_pkg::LETTER_W-1:0] pos_raddr;
	logic [pfc_pkg::POS_W-1:0]    pos_rdata;
	logic                         sq_re;
	logic [pfc_pkg::LETTER_W-1:0] sq_raddr;
	logic [pfc_pkg::LETTER_W-1:0] sq_rdata;
	logic                         out_load;
	logic                         out_load_last;

	logic [pfc_pkg::COORD_W-1:0]  r1, c1, r2, c2;
	logic [pfc_pkg::LETTER_W-1:0] idx1;
	logic [pfc_pkg::LETTER_W-1:0] idx2;

	function automatic logic [pfc_pkg::COORD_W-1:0] step(
		input logic [pfc_pkg::COORD_W-1:0] x,
		input logic                        back
	);
		if (back) begin
			return (x == '0) ? pfc_pkg::SIDE_LAST : x - 1'b1;
		end
		return (x == pfc_pkg::SIDE_LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [pfc_pkg::LETTER_W-1:0] cell_idx(
		input logic [pfc_pkg::COORD_W-1:0] r,
		input logic [pfc_pkg::COORD_W-1:0] c
	);
		logic [pfc_pkg::LETTER_W:0] s;
		s = ({3'b000, r} << 2) + {3'b000, r} + {3'b000, c};
		return s[pfc_pkg::LETTER_W-1:0];
	endfunction

	assign out_free = !out_valid_q || out_ready;

	// digraph rule on the two looked-up positions
	always_comb begin
		r1 = pos_a_q[pfc_pkg::POS_W-1:pfc_pkg::COORD_W];
		c1 = pos_a_q[pfc_pkg::COORD_W-1:0];
		r2 = pos_rdata[pfc_pkg::POS_W-1:pfc_pkg::COORD_W];
		c2 = pos_rdata[pfc_pkg::COORD_W-1:0];
		if (r1 == r2) begin
			idx1 = cell_idx(r1, step(c1, mode));
			idx2 = cell_idx(r2, step(c2, mode));
		end else if (c1 == c2) begin
			idx1 = cell_idx(step(r1, mode), c1);
			idx2 = cell_idx(step(r2, mode), c2);
		end else begin
			idx1 = cell_idx(r1, c2);
			idx2 = cell_idx(r2, c1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfc_pkg::ST_IDLE: begin
				if (!q_empty) begin
					case (q_data.op)
						pfc_pkg::OP_FILL: state_d = pfc_pkg::ST_FILL;
						pfc_pkg::OP_PAIR: state_d = pfc_pkg::ST_RDB;
						default:          state_d = pfc_pkg::ST_IDLE;
					endcase
				end
			end
			pfc_pkg::ST_FILL: begin
				if (cnt_q == pfc_pkg::LETTER_LAST) begin
					state_d = pfc_pkg::ST_IDLE;
				end
			end
			pfc_pkg::ST_RDB:   state_d = pfc_pkg::ST_CALC;
			pfc_pkg::ST_CALC:  state_d = pfc_pkg::ST_EMIT1;
			pfc_pkg::ST_EMIT1: begin
				if (out_free) begin
					state_d = pfc_pkg::ST_EMIT2;
				end
			end
			pfc_pkg::ST_EMIT2: begin
				if (out_free) begin
					state_d = pfc_pkg::ST_IDLE;
				end
			end
			default: state_d = pfc_pkg::ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		q_pop         = 1'b0;
		clr           = 1'b0;
		place_en      = 1'b0;
		place_letter  = q_data.a;
		pos_re        = 1'b0;
		pos_raddr     = q_data.a;
		sq_re         = 1'b0;
		sq_raddr      = idx1;
		out_load      = 1'b0;
		out_load_last = 1'b0;
		case (state_q)
			pfc_pkg::ST_IDLE: begin
				q_pop  = !q_empty;
				clr    = !q_empty && (q_data.op == pfc_pkg::OP_CLR);
				place_en = !q_empty && (q_data.op == pfc_pkg::OP_PLACE);
				pos_re = !q_empty && (q_data.op == pfc_pkg::OP_PAIR);
			end
			pfc_pkg::ST_FILL: begin
				place_en     = 1'b1;
				place_letter = pfc_pkg::fold(cnt_q);
			end
			pfc_pkg::ST_RDB: begin
				pos_re    = 1'b1;
				pos_raddr = b_q;
			end
			pfc_pkg::ST_CALC: begin
				sq_re = 1'b1;
			end
			pfc_pkg::ST_EMIT1: begin
				out_load = out_free;
				sq_re    = out_free;
				sq_raddr = idx2_q;
			end
			pfc_pkg::ST_EMIT2: begin
				out_load      = out_free;
				out_load_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign place_ok = place_en && (slot_q < pfc_pkg::SLOT_FULL) && !placed_q[place_letter];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfc_pkg::ST_IDLE;
			placed_q    <= '0;
			slot_q      <= '0;
			slot_row_q  <= '0;
			slot_col_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr) begin
				placed_q   <= '0;
				slot_q     <= '0;
				slot_row_q <= '0;
				slot_col_q <= '0;
			end else if (place_ok) begin
				placed_q[place_letter] <= 1'b1;
				slot_q <= slot_q + 1'b1;
				if (slot_col_q == pfc_pkg::SIDE_LAST) begin
					slot_col_q <= '0;
					slot_row_q <= slot_row_q + 1'b1;
				end else begin
					slot_col_q <= slot_col_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfc_pkg::ST_IDLE) begin
			cnt_q <= '0;
			b_q   <= q_data.b;
		end else if (state_q == pfc_pkg::ST_FILL) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == pfc_pkg::ST_RDB) begin
			pos_a_q <= pos_rdata;
		end
		if (state_q == pfc_pkg::ST_CALC) begin
			idx2_q <= idx2;
		end
		if (out_load) begin
			out_letter_q <= sq_rdata;
			out_last_q   <= out_load_last;
		end
	end

	// letter -> {row, col}
	pfc_ram #(
		.WIDTH(pfc_pkg::POS_W),
		.DEPTH(pfc_pkg::ALPHABET)
	) u_pos_ram (
		.clk  (clk),
		.we   (place_ok),
		.waddr(place_letter),
		.wdata({slot_row_q, slot_col_q}),
		.re   (pos_re),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	// cell -> letter
	pfc_ram #(
		.WIDTH(pfc_pkg::LETTER_W),
		.DEPTH(pfc_pkg::CELLS)
	) u_sq_ram (
		.clk  (clk),
		.we   (place_ok),
		.waddr(slot_q),
		.wdata(place_letter),
		.re   (sq_re),
		.raddr(sq_raddr),
		.rdata(sq_rdata)
	);

	assign out_valid  = out_valid_q;
	assign out_letter = out_letter_q;
	assign out_last   = out_last_q;

endmodule

// ----- bench/playfair_cipher_top_tb.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_top_tb
// self-checking bench for the playfair cipher engine
// ----------------------------------------------------------------------------
// a directed run loads a key with folded, repeated and out-of-range letters,
// completes it and sends text that hits the same-row, same-column and
// rectangle rules, doubled letters, x padding and the ignored commands.
// random phases then send key/text sessions mixed with noise commands under
// several idle and stall patterns, both cipher directions, and one long
// receiver hold-off. every accepted command runs through a local copy of the
// key square and every cipher letter is checked against the oldest expected one
// ----------------------------------------------------------------------------
module playfair_cipher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	localparam int SIDE           = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 128;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_ITEMS    = 280;
	localparam int PRESSURE_ITEMS = 200;

	// codes the block must drop
	localparam logic [CMD_W-1:0]    CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0]    CMD_UNUSED_HI = 3'd7;
	localparam logic [LETTER_W-1:0] LETTER_OVER   = 5'd26;
	localparam logic [LETTER_W-1:0] LETTER_BAD    = 5'd31;

	// letters used by the directed run
	localparam logic [LETTER_W-1:0] L_A = 5'd0;
	localparam logic [LETTER_W-1:0] L_B = 5'd1;
	localparam logic [LETTER_W-1:0] L_D = 5'd3;
	localparam logic [LETTER_W-1:0] L_K = 5'd10;
	localparam logic [LETTER_W-1:0] L_P = 5'd15;
	localparam logic [LETTER_W-1:0] L_Y = 5'd24;
	localparam logic [LETTER_W-1:0] L_Z = 5'd25;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [LETTER_W-1:0] letter;
	} cmd_item_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last;
	} cipher_out_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_wen   = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = '0;    // [4:0] letter, [7:5] zero
	logic [2:0] s_tuser   = '0;    // [2:0] cmd
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;           // [4:0] out_letter, [7:5] zero
	logic       m_tlast;

	playfair_cipher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// local copy of the key square and the digraph state
	// ------------------------------------------------------------------
	logic [LETTER_W-1:0] key_square [CELLS]    = '{default: '0};
	logic [COORD_W-1:0]  row_of     [ALPHABET] = '{default: '0};
	logic [COORD_W-1:0]  col_of     [ALPHABET] = '{default: '0};
	logic [ALPHABET-1:0] placed_set   = '0;
	logic [LETTER_W-1:0] next_slot    = '0;
	logic [LETTER_W-1:0] held_letter  = '0;
	logic                held_valid   = 1'b0;
	logic                decrypt_mode = 1'b0;

	cipher_out_t expected_letters [$];
	cmd_item_t   cmd_backlog [$];
	cmd_item_t   shown;

	int  mismatches     = 0;
	int  src_idle_pct   = 0;
	int  sink_stall_pct = 0;
	logic sink_hold     = 1'b0;
	bit  holdoff_go     = 1'b0;

	task automatic place_letter(input logic [LETTER_W-1:0] raw);
		logic [LETTER_W-1:0] c;
		c = (raw == LETTER_J) ? LETTER_I : raw;
		if (c > LETTER_LAST || next_slot >= SLOT_FULL)
			return;
		if (placed_set[c])
			return;
		placed_set[c] = 1'b1;
		key_square[next_slot] = c;
		row_of[c] = COORD_W'(next_slot / SIDE);
		col_of[c] = COORD_W'(next_slot % SIDE);
		next_slot = next_slot + 1'b1;
	endtask

	// two cipher letters of one digraph
	task automatic cipher_digraph(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b);
		int r1;
		int c1;
		int r2;
		int c2;
		int step;
		logic [LETTER_W-1:0] o1;
		logic [LETTER_W-1:0] o2;
		r1 = row_of[a];
		c1 = col_of[a];
		r2 = row_of[b];
		c2 = col_of[b];
		step = decrypt_mode ? SIDE - 1 : 1;
		if (r1 == r2) begin
			o1 = key_square[r1 * SIDE + (c1 + step) % SIDE];
			o2 = key_square[r2 * SIDE + (c2 + step) % SIDE];
		end else if (c1 == c2) begin
			o1 = key_square[((r1 + step) % SIDE) * SIDE + c1];
			o2 = key_square[((r2 + step) % SIDE) * SIDE + c2];
		end else begin
			o1 = key_square[r1 * SIDE + c2];
			o2 = key_square[r2 * SIDE + c1];
		end
		expected_letters.push_back('{letter: o1, last: 1'b0});
		expected_letters.push_back('{letter: o2, last: 1'b1});
	endtask

	task automatic cipher_command(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter);
		logic [LETTER_W-1:0] l;
		case (cmd)
			CMD_START: begin
				placed_set  = '0;
				next_slot   = '0;
				held_valid  = 1'b0;
				held_letter = '0;
			end
			CMD_KEY: begin
				place_letter(letter);
			end
			CMD_FILL: begin
				for (int c = 0; c < ALPHABET; c++)
					place_letter(LETTER_W'(c));
			end
			CMD_TEXT: begin
				if (letter <= LETTER_LAST) begin
					l = (letter == LETTER_J) ? LETTER_I : letter;
					if (!held_valid) begin
						held_letter = l;
						held_valid  = 1'b1;
					end else if (l == held_letter) begin
						// doubled letter: pad with x, the repeat stays pending
						cipher_digraph(held_letter, LETTER_X);
					end else begin
						held_valid = 1'b0;
						cipher_digraph(held_letter, l);
					end
				end
			end
			CMD_END: begin
				if (held_valid) begin
					held_valid = 1'b0;
					cipher_digraph(held_letter, LETTER_X);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk)
		if (cfg_wen)
			decrypt_mode <= cfg_wdata;

	// ------------------------------------------------------------------
	// command driver: one item held until taken, random gaps between items
	// ------------------------------------------------------------------
	always @(posedge clk) begin : cmd_driver
		logic offer;
		if (s_tvalid && s_tready)
			cipher_command(shown.cmd, shown.letter);
		if (!s_tvalid || s_tready) begin
			offer = arst_n && cmd_backlog.size() != 0 &&
				($urandom_range(99) >= src_idle_pct);
			if (offer) begin
				shown = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= shown.cmd;
				s_tdata  <= {3'b000, shown.letter};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor with random back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin : letter_monitor
		cipher_out_t want;
		if (m_tvalid && m_tready) begin
			if (expected_letters.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected item: letter %0d last %0b at %0t",
						m_tdata[LETTER_W-1:0], m_tlast, $realtime);
			end else begin
				want = expected_letters.pop_front();
				if (m_tdata[LETTER_W-1:0] !== want.letter || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: expected letter %0d last %0b, got letter %0d last %0b at %0t",
							want.letter, want.last, m_tdata[LETTER_W-1:0], m_tlast,
							$realtime);
				end
			end
		end
		m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
	end

	// long receiver hold-off so the front stage and queue fill up
	initial begin : sink_holdoff
		wait (holdoff_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l);
		cmd_backlog.push_back('{cmd: c, letter: l});
	endtask

	function automatic logic [LETTER_W-1:0] rand_letter();
		int roll;
		roll = $urandom_range(15);
		if (roll == 0)
			return LETTER_W'($urandom_range(31, 26));
		if (roll == 1)
			return LETTER_J;
		if (roll == 2)
			return LETTER_X;
		return LETTER_W'($urandom_range(25));
	endfunction

	// start key, some key letters, usually complete key, text, usually end
	task automatic queue_session();
		int n_key;
		int n_text;
		logic [LETTER_W-1:0] prev;
		logic [LETTER_W-1:0] pick;
		prev = L_A;
		queue_cmd(CMD_START, LETTER_W'($urandom_range(31)));
		n_key = ($urandom_range(7) == 0) ? 30 : $urandom_range(10);
		repeat (n_key)
			queue_cmd(CMD_KEY, rand_letter());
		if ($urandom_range(9) != 0)
			queue_cmd(CMD_FILL, LETTER_W'($urandom_range(31)));
		n_text = $urandom_range(14, 1);
		for (int k = 0; k < n_text; k++) begin
			pick = (k != 0 && $urandom_range(4) == 0) ? prev : rand_letter();
			queue_cmd(CMD_TEXT, pick);
			prev = pick;
		end
		if ($urandom_range(3) != 0)
			queue_cmd(CMD_END, LETTER_W'($urandom_range(31)));
	endtask

	task automatic queue_random(input int n_items);
		int target;
		target = cmd_backlog.size() + n_items;
		while (cmd_backlog.size() < target) begin
			if ($urandom_range(6) == 0) begin
				repeat ($urandom_range(3, 1))
					queue_cmd(CMD_W'($urandom_range(7)), LETTER_W'($urandom_range(31)));
			end else begin
				queue_session();
			end
		end
	endtask

	// wait until everything sent has been answered, then let a complete key finish
	task automatic drain();
		while (cmd_backlog.size() != 0 || s_tvalid || expected_letters.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic dec);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= dec;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic run_phase(input logic dec, input int src, input int sink, input int n_items);
		write_mode(dec);
		@(negedge clk);
		src_idle_pct   = src;
		sink_stall_pct = sink;
		queue_random(n_items);
		drain();
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_mode(1'b0);
		@(negedge clk);
		// key: j folds into i, a repeat after folding and a bad letter are skipped
		queue_cmd(CMD_START, L_A);
		queue_cmd(CMD_KEY, L_P);
		queue_cmd(CMD_KEY, LETTER_J);
		queue_cmd(CMD_KEY, LETTER_I);
		queue_cmd(CMD_KEY, LETTER_BAD);
		queue_cmd(CMD_KEY, L_Z);
		queue_cmd(CMD_KEY, L_A);
		queue_cmd(CMD_FILL, L_A);
		// square full: key letter and complete key do nothing
		queue_cmd(CMD_KEY, L_B);
		queue_cmd(CMD_FILL, LETTER_BAD);
		// doubled letter, j in text, x against x, end with and without pending
		queue_cmd(CMD_TEXT, L_A);
		queue_cmd(CMD_TEXT, L_A);
		queue_cmd(CMD_TEXT, LETTER_J);
		queue_cmd(CMD_TEXT, LETTER_X);
		queue_cmd(CMD_TEXT, LETTER_X);
		queue_cmd(CMD_END, L_A);
		queue_cmd(CMD_END, L_A);
		// dropped items
		queue_cmd(CMD_TEXT, LETTER_OVER);
		queue_cmd(CMD_TEXT, LETTER_BAD);
		queue_cmd(CMD_UNUSED_LO, L_D);
		queue_cmd(CMD_UNUSED_HI, LETTER_BAD);
		// same row, same column with wrap, rectangle
		queue_cmd(CMD_TEXT, L_P);
		queue_cmd(CMD_TEXT, L_Z);
		queue_cmd(CMD_TEXT, L_B);
		queue_cmd(CMD_TEXT, L_Y);
		queue_cmd(CMD_TEXT, L_D);
		queue_cmd(CMD_TEXT, L_B);
		// start key drops a pending text letter
		queue_cmd(CMD_TEXT, L_K);
		queue_cmd(CMD_START, LETTER_BAD);
		queue_cmd(CMD_END, L_A);
		drain();

		run_phase(1'b1, 0, 0, PHASE_ITEMS);
		run_phase(1'b0, 70, 0, PHASE_ITEMS);
		run_phase(1'b1, 0, 70, PHASE_ITEMS);
		run_phase(1'b0, 38, 38, PHASE_ITEMS);

		// sender keeps offering while the receiver holds off
		write_mode(1'b0);
		@(negedge clk);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		holdoff_go     = 1'b1;
		queue_random(PRESSURE_ITEMS);
		drain();

		run_phase(1'b1, 38, 38, PHASE_ITEMS);

		if (mismatches == 0 && expected_letters.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/pfc_pkg.sv
design/pfc_ram.sv
design/pfc_queue.sv
design/pfc_front.sv
design/pfc_back.sv
design/playfair_cipher_top.sv
bench/playfair_cipher_top_tb.sv
